/* hw/rtl/hpd_pkg.sv */
// Shared types, codes and constants for the PD heading turn controller.
// No dependencies; every other file of the block refers to it by scoped names.
package hpd_pkg;

  // Default structural parameters
  localparam int STALL_PERIOD_DEF = 50;
  localparam int ANGLE_BITS_DEF   = 16;

  // Field widths fixed by the channel payloads
  localparam int HEADING_W = 16;
  localparam int GAIN_W    = 16;
  localparam int BAND_W    = 15;
  localparam int TICKS_W   = 8;
  localparam int DRIVE_W   = 16;
  localparam int REASON_W  = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  // Settle counter saturation point
  localparam logic [TICKS_W-1:0] SETTLE_MAX = '1;

  // Q8.8 gains: the PD sum drops this many fraction bits
  localparam int FRAC_BITS = 8;

  // Exit reason codes
  localparam logic [REASON_W-1:0] EXIT_RUN     = 2'd0;
  localparam logic [REASON_W-1:0] EXIT_EARLY   = 2'd1;
  localparam logic [REASON_W-1:0] EXIT_SETTLED = 2'd2;
  localparam logic [REASON_W-1:0] EXIT_STALL   = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_HEADING  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_P_GAIN          = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_D_GAIN          = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE_BAND     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE_TICKS    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STALL_BAND      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_EARLY_EXIT_BAND = 3'd7;

  // Reset values of the configuration registers
  localparam logic [HEADING_W-1:0] TARGET_HEADING_RST  = 16'd0;
  localparam logic [GAIN_W-1:0]    P_GAIN_RST          = 16'd534;
  localparam logic [GAIN_W-1:0]    D_GAIN_RST          = 16'd2813;
  localparam logic [BAND_W-1:0]    DRIVE_LIMIT_RST     = 15'd11000;
  localparam logic [BAND_W-1:0]    SETTLE_BAND_RST     = 15'd546;
  localparam logic [TICKS_W-1:0]   SETTLE_TICKS_RST    = 8'd8;
  localparam logic [BAND_W-1:0]    STALL_BAND_RST      = 15'd728;
  localparam logic [BAND_W-1:0]    EARLY_EXIT_BAND_RST = 15'd0;

  typedef struct packed {
    logic [HEADING_W-1:0] target_heading;
    logic [GAIN_W-1:0]    p_gain;
    logic [GAIN_W-1:0]    d_gain;
    logic [BAND_W-1:0]    drive_limit;
    logic [BAND_W-1:0]    settle_band;
    logic [TICKS_W-1:0]   settle_ticks;
    logic [BAND_W-1:0]    stall_band;
    logic [BAND_W-1:0]    early_exit_band;
  } cfg_t;

endpackage

/* hw/rtl/hpd_if.sv */
// Valid/ready channel interfaces of the PD heading turn controller.
// Depends on hpd_pkg for payload widths.

// Measurement channel: one heading sample per control tick
interface hpd_meas_if;
  logic                            valid;
  logic                            ready;
  logic [hpd_pkg::HEADING_W-1:0]   heading;
  logic                            start_req;
  modport source (output valid, heading, start_req, input ready);
  modport sink   (input valid, heading, start_req, output ready);
endinterface

// Command channel: one drive result per control tick
interface hpd_cmd_if;
  logic                                valid;
  logic                                ready;
  logic signed [hpd_pkg::DRIVE_W-1:0]  drive;
  logic                                drive_valid;
  logic                                finished;
  logic [hpd_pkg::REASON_W-1:0]        exit_reason;
  modport source (output valid, drive, drive_valid, finished, exit_reason, input ready);
  modport sink   (input valid, drive, drive_valid, finished, exit_reason, output ready);
endinterface

// Configuration write channel
interface hpd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [hpd_pkg::CFG_IDX_W-1:0]   index;
  logic [hpd_pkg::CFG_DAT_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/hpd_cfg_regs.sv */
// Configuration register file of the PD heading turn controller.
// Depends on hpd_pkg and hpd_cfg_if.
module hpd_cfg_regs (
  input  logic            clk,
  input  logic            rst,
  hpd_cfg_if.sink         cfg,
  output hpd_pkg::cfg_t   regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.target_heading  <= hpd_pkg::TARGET_HEADING_RST;
      regs.p_gain          <= hpd_pkg::P_GAIN_RST;
      regs.d_gain          <= hpd_pkg::D_GAIN_RST;
      regs.drive_limit     <= hpd_pkg::DRIVE_LIMIT_RST;
      regs.settle_band     <= hpd_pkg::SETTLE_BAND_RST;
      regs.settle_ticks    <= hpd_pkg::SETTLE_TICKS_RST;
      regs.stall_band      <= hpd_pkg::STALL_BAND_RST;
      regs.early_exit_band <= hpd_pkg::EARLY_EXIT_BAND_RST;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        hpd_pkg::REG_TARGET_HEADING:  regs.target_heading  <= cfg.data;
        hpd_pkg::REG_P_GAIN:          regs.p_gain          <= cfg.data;
        hpd_pkg::REG_D_GAIN:          regs.d_gain          <= cfg.data;
        hpd_pkg::REG_DRIVE_LIMIT:     regs.drive_limit     <= cfg.data[hpd_pkg::BAND_W-1:0];
        hpd_pkg::REG_SETTLE_BAND:     regs.settle_band     <= cfg.data[hpd_pkg::BAND_W-1:0];
        hpd_pkg::REG_SETTLE_TICKS:    regs.settle_ticks    <= cfg.data[hpd_pkg::TICKS_W-1:0];
        hpd_pkg::REG_STALL_BAND:      regs.stall_band      <= cfg.data[hpd_pkg::BAND_W-1:0];
        hpd_pkg::REG_EARLY_EXIT_BAND: regs.early_exit_band <= cfg.data[hpd_pkg::BAND_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* hw/rtl/hpd_pd_law.sv */
// PD control law: registered gain products, then sum, floor shift and saturation.
// Depends on hpd_pkg.
module hpd_pd_law #(
  parameter int ANGLE_BITS = hpd_pkg::ANGLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              load,
  input  logic signed [ANGLE_BITS-1:0]      err,
  input  logic signed [ANGLE_BITS:0]        deriv,
  input  logic [hpd_pkg::GAIN_W-1:0]        p_gain,
  input  logic [hpd_pkg::GAIN_W-1:0]        d_gain,
  input  logic [hpd_pkg::BAND_W-1:0]        drive_limit,
  output logic signed [hpd_pkg::DRIVE_W-1:0] drive
);

  localparam int PW = ANGLE_BITS + hpd_pkg::GAIN_W + 1;
  localparam int DW = ANGLE_BITS + hpd_pkg::GAIN_W + 2;
  localparam int SW = DW + 1;
  localparam int MW = SW - hpd_pkg::FRAC_BITS;

  logic signed [PW-1:0] p_prod;
  logic signed [DW-1:0] d_prod;
  logic signed [SW-1:0] sum;
  logic signed [MW-1:0] mv;
  logic signed [MW-1:0] lim;
  logic signed [MW-1:0] cmd;

  // Products registered before the sum
  always_ff @(posedge clk) begin
    if (load) begin
      p_prod <= PW'($signed({1'b0, p_gain})) * PW'(err);
      d_prod <= DW'($signed({1'b0, d_gain})) * DW'(deriv);
    end
  end

  always_comb begin
    sum = SW'(p_prod) + SW'(d_prod);
    mv  = MW'(sum >>> hpd_pkg::FRAC_BITS);
    lim = MW'($signed({1'b0, drive_limit}));
    if (mv > lim) begin
      cmd = -lim;
    end else if (mv < -lim) begin
      cmd = lim;
    end else begin
      cmd = -mv;
    end
    drive = cmd[hpd_pkg::DRIVE_W-1:0];
  end

endmodule

/* hw/rtl/heading_pd_turn_controller_core.sv */
// Top level of the PD heading turn controller with settle and stall detection.
// Depends on hpd_pkg, hpd_if, hpd_cfg_regs and hpd_pd_law.
//
//   channel | modport | transaction carries                          | when
//   --------+---------+---------------------------------------------+----------------------
//   meas    | sink    | heading, start_req                          | valid && ready
//   cmd     | source  | drive, drive_valid, finished, exit_reason   | valid && ready
//   cfg     | sink    | index, data (register write)                | valid && ready
//
// One meas transaction enters per cycle while meas.ready is high; its cmd transaction leaves
// after the decision stage, product stage and output register. The decision stage closes the
// state loop (previous error, settle and stall counters) in the accepting cycle.
// Stalls on cmd back up stage by stage; meas.ready drops only once every stage is full.
// Synchronous active-high reset clears the stage valids and controller state and loads the config reset values.
module heading_pd_turn_controller_core #(
  parameter int STALL_PERIOD = hpd_pkg::STALL_PERIOD_DEF,
  parameter int ANGLE_BITS   = hpd_pkg::ANGLE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  hpd_meas_if.sink  meas,
  hpd_cmd_if.source cmd,
  hpd_cfg_if.sink   cfg
);

  localparam int TW  = (STALL_PERIOD > 2) ? $clog2(STALL_PERIOD) : 1;
  localparam int DVW = ANGLE_BITS + 1;
  // Compare widths wide enough for both the magnitude and a 15-bit band
  localparam int MCW = ((ANGLE_BITS > hpd_pkg::BAND_W) ? ANGLE_BITS : hpd_pkg::BAND_W) + 1;
  localparam int SCW = ((DVW > hpd_pkg::BAND_W) ? DVW : hpd_pkg::BAND_W) + 1;
  localparam logic [TW-1:0] TICK_LAST = TW'(STALL_PERIOD - 1);

  hpd_pkg::cfg_t regs;

  hpd_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // ---------------------------------------------------------------------------
  // Controller state
  // ---------------------------------------------------------------------------
  logic signed [ANGLE_BITS-1:0]     previous_error, previous_error_next;
  logic [hpd_pkg::TICKS_W-1:0]      settle_count, settle_count_next;
  logic [TW-1:0]                    tick_count, tick_count_next;
  logic signed [ANGLE_BITS-1:0]     stall_sample, stall_sample_next;

  // Pipeline stage valids and payloads
  logic                             valid_a, valid_b;
  logic signed [ANGLE_BITS-1:0]     err_a;
  logic signed [DVW-1:0]            deriv_a;
  logic [hpd_pkg::REASON_W-1:0]     reason_a, reason_b;

  logic ready_a, ready_b, ready_c;
  logic take;

  // Ready ripples back from the output register
  assign ready_c    = !cmd.valid || cmd.ready;
  assign ready_b    = !valid_b || ready_c;
  assign ready_a    = !valid_a || ready_b;
  assign meas.ready = ready_a;
  assign take       = meas.valid && ready_a;

  // ---------------------------------------------------------------------------
  // Decision stage: error, derivative, exit tests and state update
  // ---------------------------------------------------------------------------
  logic [ANGLE_BITS-1:0]        tgt, hdg, diff, mag;
  logic signed [ANGLE_BITS-1:0] err;
  logic signed [DVW-1:0]        deriv, stall_diff;
  logic [DVW-1:0]               stall_mag;
  logic [TW-1:0]                tick_eff;
  logic signed [ANGLE_BITS-1:0] sample_eff;
  logic [hpd_pkg::TICKS_W-1:0]  settle_inc;
  logic                         early, settled, stalled;
  logic [hpd_pkg::REASON_W-1:0] reason;

  always_comb begin
    tgt   = ANGLE_BITS'(regs.target_heading);
    hdg   = ANGLE_BITS'(meas.heading);
    diff  = tgt - hdg;
    err   = $signed(diff);
    mag   = err[ANGLE_BITS-1] ? -diff : diff;
    deriv = DVW'(err) - DVW'(previous_error);

    // start_req opens a move: restart the stall check
    tick_eff   = meas.start_req ? '0 : tick_count;
    sample_eff = meas.start_req ? '0 : stall_sample;

    stall_diff = DVW'(sample_eff) - DVW'(err);
    stall_mag  = stall_diff[DVW-1] ? DVW'(-stall_diff) : DVW'(stall_diff);

    settle_inc = (settle_count == hpd_pkg::SETTLE_MAX) ? settle_count : settle_count + 1'b1;

    // Hold state by default
    previous_error_next = previous_error;
    settle_count_next   = settle_count;
    tick_count_next     = tick_eff;
    stall_sample_next   = sample_eff;
    settled             = 1'b0;
    stalled             = 1'b0;
    reason              = hpd_pkg::EXIT_RUN;

    early = (regs.early_exit_band != '0) && (MCW'(mag) < MCW'(regs.early_exit_band));

    if (early) begin
      reason = hpd_pkg::EXIT_EARLY;
    end else begin
      settle_count_next = (MCW'(mag) < MCW'(regs.settle_band)) ? settle_inc : '0;
      settled = settle_count_next >= regs.settle_ticks;
      if (settled) begin
        settle_count_next = '0;
        reason            = hpd_pkg::EXIT_SETTLED;
      end else begin
        previous_error_next = err;
        if (tick_eff == '0) begin
          stalled = SCW'(stall_mag) < SCW'(regs.stall_band);
        end
        if (stalled) begin
          reason = hpd_pkg::EXIT_STALL;
        end else begin
          if (tick_eff == '0) begin
            stall_sample_next = err;
          end
          tick_count_next = (tick_eff == TICK_LAST) ? '0 : tick_eff + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_error <= '0;
      settle_count   <= '0;
      tick_count     <= '0;
      stall_sample   <= '0;
    end else if (take) begin
      previous_error <= previous_error_next;
      settle_count   <= settle_count_next;
      tick_count     <= tick_count_next;
      stall_sample   <= stall_sample_next;
    end
  end

  // Stage A register: advance on accept, drop when passed on
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
    end else if (ready_a) begin
      valid_a <= meas.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      err_a    <= err;
      deriv_a  <= deriv;
      reason_a <= reason;
    end
  end

  // ---------------------------------------------------------------------------
  // Product stage (inside hpd_pd_law) and output register
  // ---------------------------------------------------------------------------
  logic load_b;
  logic signed [hpd_pkg::DRIVE_W-1:0] drive_b;

  assign load_b = valid_a && ready_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_b <= 1'b0;
    end else if (ready_b) begin
      valid_b <= valid_a;
    end
  end

  always_ff @(posedge clk) begin
    if (load_b) begin
      reason_b <= reason_a;
    end
  end

  hpd_pd_law #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_pd_law (
    .clk         (clk),
    .load        (load_b),
    .err         (err_a),
    .deriv       (deriv_a),
    .p_gain      (regs.p_gain),
    .d_gain      (regs.d_gain),
    .drive_limit (regs.drive_limit),
    .drive       (drive_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd.valid <= 1'b0;
    end else if (ready_c) begin
      cmd.valid <= valid_b;
    end
  end

  // Early exit and settle both command zero; only early exit withholds the command
  always_ff @(posedge clk) begin
    if (valid_b && ready_c) begin
      cmd.exit_reason <= reason_b;
      cmd.finished    <= (reason_b != hpd_pkg::EXIT_RUN);
      cmd.drive_valid <= (reason_b != hpd_pkg::EXIT_EARLY);
      if (reason_b == hpd_pkg::EXIT_EARLY || reason_b == hpd_pkg::EXIT_SETTLED) begin
        cmd.drive <= '0;
      end else begin
        cmd.drive <= drive_b;
      end
    end
  end

endmodule

/* hw/rtl/hpd_checker.sv */
// Port-level checks of the PD heading turn controller, bound to the top level.
// Depends on hpd_pkg and heading_pd_turn_controller_core.
module hpd_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               cmd_valid,
  input logic                               cmd_ready,
  input logic signed [hpd_pkg::DRIVE_W-1:0] cmd_drive,
  input logic                               cmd_drive_valid,
  input logic                               cmd_finished,
  input logic [hpd_pkg::REASON_W-1:0]       cmd_exit_reason
);

  // A stalled result holds
  a_cmd_hold: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd_drive) && $stable(cmd_exit_reason))
    else $error("cmd payload changed while stalled");

  // No result appears in the cycle after reset
  a_rst_quiet: assert property (@(posedge clk) rst |=> !cmd_valid)
    else $error("cmd valid right after reset");

  // finished and a nonzero exit reason go together
  a_finish_code: assert property (@(posedge clk) disable iff (rst)
    cmd_valid |-> (cmd_finished == (cmd_exit_reason != hpd_pkg::EXIT_RUN)))
    else $error("finished disagrees with exit_reason");

  // Early exit and settle both stop the motors
  a_stop_zero: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && (cmd_exit_reason == hpd_pkg::EXIT_EARLY ||
                  cmd_exit_reason == hpd_pkg::EXIT_SETTLED)
    |-> cmd_drive == '0 && (cmd_drive_valid == (cmd_exit_reason == hpd_pkg::EXIT_SETTLED)))
    else $error("stop result carries a drive");

  // Saturation never yields the most negative code
  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    cmd_valid |-> cmd_drive != {1'b1, {(hpd_pkg::DRIVE_W-1){1'b0}}})
    else $error("drive out of range");

endmodule

bind heading_pd_turn_controller_core hpd_checker u_hpd_checker (
  .clk             (clk),
  .rst             (rst),
  .cmd_valid       (cmd.valid),
  .cmd_ready       (cmd.ready),
  .cmd_drive       (cmd.drive),
  .cmd_drive_valid (cmd.drive_valid),
  .cmd_finished    (cmd.finished),
  .cmd_exit_reason (cmd.exit_reason)
);
